// ----- hw/rtl/rwlt_pkg.sv -----
// ---------------------------------------------------------------------------
// Readers-writer lock table package
// Shared types, codes and constants of the lock table and its sub-blocks.
// ---------------------------------------------------------------------------
package rwlt_pkg;

    localparam int MAX_RESOURCES_DEF = 16;
    localparam int WAIT_DEPTH_DEF    = 8;

    localparam int PID_W     = 16;
    localparam int READERS_W = 8;
    localparam int FILE_W    = 4;
    localparam int NFILES_W  = 5;
    localparam int STAT_W    = 32;

    localparam logic [NFILES_W-1:0]  NUM_FILES_RST = 5'd16;
    localparam logic [READERS_W-1:0] READERS_MAX   = 8'd255;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 208;
    localparam int OUT_USED_W  = 205;

    // Bit positions in the result tdata.
    localparam int OUT_STATUS_LSB  = 0;
    localparam int OUT_DEQV_BIT    = 2;
    localparam int OUT_GRANTS_LSB  = 77;
    localparam int OUT_READS_LSB   = 109;
    localparam int OUT_WRITES_LSB  = 141;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;
    localparam logic MODE_READ    = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_QUEUED = 2'd1,
        ST_NO_RES = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [PID_W-1:0]     owner;
        logic                 active;
        logic                 writer;
        logic [READERS_W-1:0] readers;
    } t_lock;

    typedef struct packed {
        logic conflict;
        logic grant;
        logic read_grant;
        logic write_grant;
        logic resolved;
    } t_stat_evt;

    typedef struct packed {
        t_status          status;
        logic             wr_en;
        logic             deq_valid;
        logic [PID_W-1:0] deq_pid;
        t_stat_evt        evt;
    } t_step_info;

    typedef struct packed {
        logic [STAT_W-1:0] resolved;
        logic [STAT_W-1:0] writes;
        logic [STAT_W-1:0] reads;
        logic [STAT_W-1:0] grants;
        logic [STAT_W-1:0] conflicts;
    } t_stats;

endpackage

// ----- hw/rtl/reader_writer_lock_table.sv -----
// ---------------------------------------------------------------------------
// Readers-writer lock table
// Per-resource readers-writer locks, each with a FIFO of waiting requesters.
// ---------------------------------------------------------------------------
// The block takes one request per clock cycle and gives one result for each.
// A request sits in the input register while the resource's row is read from
// the table memory, and its result then sits in the result register.
// Each row holds the lock state, the waiter count and the whole waiter queue
// of one resource, so a request is a single read-modify-write of one row; the
// row for the next request is read while the current one is written, and the
// written row is forwarded when both name the same resource. Rows are marked
// valid in flip-flops cleared by reset, so no clearing pass is needed after
// reset. Full throughput holds as long as the result side takes results.
module reader_writer_lock_table #(
    parameter int MAX_RESOURCES = rwlt_pkg::MAX_RESOURCES_DEF,
    parameter int WAIT_DEPTH    = rwlt_pkg::WAIT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rwlt_pkg::NFILES_W-1:0]       i_cfg_wdata,   // num_files
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // file_index[3:0], pid[19:4], mode[20], zero[23:21]
    input  logic [rwlt_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic [0:0]                          i_s_tuser,     // func
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // status[1:0], dequeued_valid[2], dequeued_pid[18:3], readers_now[26:19],
    // writer_now[27], owner_valid[28], owner_pid[44:29],
    // conflicts_total[76:45], grants_total[108:77], read_grants_total[140:109],
    // write_grants_total[172:141], resolved_total[204:173], zero[207:205]
    output logic [rwlt_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int RES_W   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CNT_W   = $clog2(WAIT_DEPTH + 1);
    localparam int LOCK_W  = $bits(rwlt_pkg::t_lock);
    localparam int QUEUE_W = WAIT_DEPTH * rwlt_pkg::PID_W;
    localparam int ROW_W   = QUEUE_W + CNT_W + LOCK_W;

    logic [rwlt_pkg::NFILES_W-1:0] r_num_files;

    logic                          r_in_valid;
    logic                          r_in_func;
    logic [rwlt_pkg::FILE_W-1:0]   r_in_file;
    logic [rwlt_pkg::PID_W-1:0]    r_in_pid;
    logic                          r_in_mode;
    logic                          r_fwd_hit;
    logic [ROW_W-1:0]              r_fwd_row;
    logic                          r_row_vld;
    logic [MAX_RESOURCES-1:0]      r_vld_bits;

    logic                          r_out_valid;
    rwlt_pkg::t_status             r_out_status;
    logic                          r_out_deqv;
    logic [rwlt_pkg::PID_W-1:0]    r_out_deq_pid;
    rwlt_pkg::t_lock               r_out_lock;

    logic                          accept;
    logic                          out_free;
    logic                          commit;
    logic                          in_range;
    logic                          wr_en;
    logic                          same_row;
    logic [RES_W-1:0]              rd_idx;
    logic [RES_W-1:0]              wr_idx;
    logic [ROW_W-1:0]              ram_q;
    logic [ROW_W-1:0]              row_cur;
    logic [ROW_W-1:0]              row_nxt;
    rwlt_pkg::t_lock               lock_cur;
    rwlt_pkg::t_lock               lock_nxt;
    logic [CNT_W-1:0]              count_cur;
    logic [CNT_W-1:0]              count_nxt;
    logic [WAIT_DEPTH-1:0][rwlt_pkg::PID_W-1:0] queue_cur;
    logic [WAIT_DEPTH-1:0][rwlt_pkg::PID_W-1:0] queue_nxt;
    rwlt_pkg::t_step_info          info;
    rwlt_pkg::t_stats              stats;

    assign out_free   = !r_out_valid || i_m_tready;
    assign commit     = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign rd_idx   = RES_W'(i_s_tdata[rwlt_pkg::FILE_W-1:0]);
    assign wr_idx   = RES_W'(r_in_file);
    assign in_range = ({1'b0, r_in_file} < r_num_files)
                   && (int'(r_in_file) < MAX_RESOURCES);
    assign wr_en    = commit && info.wr_en;
    assign same_row = wr_en && (wr_idx == rd_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_files <= rwlt_pkg::NUM_FILES_RST;
        end else if (i_cfg_we) begin
            r_num_files <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (commit) begin
            r_in_valid <= 1'b0;
        end
    end

    // The row read at acceptance misses a write made in the same cycle to
    // the same resource, so that write is kept and used instead.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_func <= i_s_tuser[0];
            r_in_file <= i_s_tdata[rwlt_pkg::FILE_W-1:0];
            r_in_pid  <= i_s_tdata[rwlt_pkg::FILE_W +: rwlt_pkg::PID_W];
            r_in_mode <= i_s_tdata[rwlt_pkg::FILE_W + rwlt_pkg::PID_W];
            r_fwd_hit <= same_row;
            r_fwd_row <= row_nxt;
            r_row_vld <= r_vld_bits[rd_idx] || same_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits <= '0;
        end else if (wr_en) begin
            r_vld_bits[wr_idx] <= 1'b1;
        end
    end

    rwlt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_RESOURCES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata (row_nxt),
        .i_re    (accept),
        .i_raddr (rd_idx),
        .o_rdata (ram_q)
    );

    // A row never written reads as an idle lock with an empty queue.
    assign row_cur   = r_fwd_hit ? r_fwd_row : ram_q;
    assign lock_cur  = r_row_vld ? rwlt_pkg::t_lock'(row_cur[LOCK_W-1:0]) : '0;
    assign count_cur = r_row_vld ? row_cur[LOCK_W +: CNT_W] : '0;
    assign queue_cur = row_cur[LOCK_W + CNT_W +: QUEUE_W];
    assign row_nxt   = {queue_nxt, count_nxt, lock_nxt};

    rwlt_step #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_step (
        .i_in_range (in_range),
        .i_func     (r_in_func),
        .i_mode     (r_in_mode),
        .i_pid      (r_in_pid),
        .i_lock     (lock_cur),
        .i_count    (count_cur),
        .i_queue    (queue_cur),
        .o_lock     (lock_nxt),
        .o_count    (count_nxt),
        .o_queue    (queue_nxt),
        .o_info     (info)
    );

    rwlt_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (commit),
        .i_evt   (info.evt),
        .o_stats (stats)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_status  <= info.status;
            r_out_deqv    <= info.deq_valid;
            r_out_deq_pid <= info.deq_pid;
            r_out_lock    <= (info.status == rwlt_pkg::ST_NO_RES) ? '0 : lock_nxt;
        end
    end

    // The counters change only when a result is loaded, so they are shown
    // straight from the statistics block.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        (rwlt_pkg::OUT_TDATA_W - rwlt_pkg::OUT_USED_W)'(0),
        stats.resolved, stats.writes, stats.reads, stats.grants, stats.conflicts,
        r_out_lock.owner, r_out_lock.active, r_out_lock.writer, r_out_lock.readers,
        r_out_deq_pid, r_out_deqv, r_out_status
    };

endmodule

// ----- hw/rtl/rwlt_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module rwlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rwlt_step.sv -----
// ---------------------------------------------------------------------------
// Lock table step logic
// Works out the new lock row of one resource and the request's outcome.
// ---------------------------------------------------------------------------
module rwlt_step #(
    parameter int WAIT_DEPTH = rwlt_pkg::WAIT_DEPTH_DEF,
    localparam int CNT_W     = $clog2(WAIT_DEPTH + 1)
) (
    input  logic                                   i_in_range,
    input  logic                                   i_func,
    input  logic                                   i_mode,
    input  logic [rwlt_pkg::PID_W-1:0]             i_pid,
    input  rwlt_pkg::t_lock                        i_lock,
    input  logic [CNT_W-1:0]                       i_count,
    input  logic [WAIT_DEPTH-1:0][rwlt_pkg::PID_W-1:0] i_queue,
    output rwlt_pkg::t_lock                        o_lock,
    output logic [CNT_W-1:0]                       o_count,
    output logic [WAIT_DEPTH-1:0][rwlt_pkg::PID_W-1:0] o_queue,
    output rwlt_pkg::t_step_info                   o_info
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WAIT_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic conflict;

    assign conflict = (i_mode == rwlt_pkg::MODE_WRITE)
                    ? ((i_lock.readers != '0) || i_lock.writer)
                    : i_lock.writer;

    always_comb begin
        o_lock  = i_lock;
        o_count = i_count;
        o_queue = i_queue;
        o_info  = '0;
        o_info.status = rwlt_pkg::ST_OK;

        if (!i_in_range) begin
            o_info.status = rwlt_pkg::ST_NO_RES;
        end else if (i_func == rwlt_pkg::FUNC_REQUEST) begin
            o_info.wr_en = 1'b1;
            if (conflict) begin
                if (i_count < DEPTH_C) begin
                    for (int i = 0; i < WAIT_DEPTH; i++) begin
                        if (CNT_W'(i) == i_count) begin
                            o_queue[i] = i_pid;
                        end
                    end
                    o_count             = i_count + ONE_C;
                    o_info.evt.conflict = 1'b1;
                    o_info.status       = rwlt_pkg::ST_QUEUED;
                end else begin
                    o_info.status = rwlt_pkg::ST_FULL;
                end
            end else if (i_mode == rwlt_pkg::MODE_WRITE) begin
                o_lock.writer          = 1'b1;
                o_lock.owner           = i_pid;
                o_lock.active          = 1'b1;
                o_info.evt.grant       = 1'b1;
                o_info.evt.write_grant = 1'b1;
            end else if (i_lock.readers == rwlt_pkg::READERS_MAX) begin
                o_info.status = rwlt_pkg::ST_FULL;
            end else begin
                o_lock.readers = i_lock.readers + 8'd1;
                // The first reader is recorded as the holder.
                if (i_lock.readers == '0) begin
                    o_lock.owner  = i_pid;
                    o_lock.active = 1'b1;
                end
                o_info.evt.grant      = 1'b1;
                o_info.evt.read_grant = 1'b1;
            end
        end else begin
            o_info.wr_en = 1'b1;
            if (i_lock.writer && (i_lock.owner == i_pid)) begin
                o_lock.writer = 1'b0;
                o_lock.active = 1'b0;
                o_lock.owner  = '0;
            end else if (i_lock.readers != '0) begin
                o_lock.readers = i_lock.readers - 8'd1;
                if (i_lock.readers == 8'd1) begin
                    o_lock.active = 1'b0;
                    o_lock.owner  = '0;
                end
            end
            // Every release pops the head waiter, if any, which gets no grant.
            if (i_count != '0) begin
                o_info.deq_valid    = 1'b1;
                o_info.deq_pid      = i_queue[0];
                for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
                    o_queue[i] = i_queue[i + 1];
                end
                o_count             = i_count - ONE_C;
                o_info.evt.resolved = 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/rwlt_stats.sv -----
// ---------------------------------------------------------------------------
// Lock table statistics
// Five wrapping event counters, updated as each request completes.
// ---------------------------------------------------------------------------
module rwlt_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  rwlt_pkg::t_stat_evt i_evt,
    output rwlt_pkg::t_stats    o_stats
);

    rwlt_pkg::t_stats r_stats;
    rwlt_pkg::t_stats n_stats;

    always_comb begin
        n_stats = r_stats;
        if (i_en) begin
            n_stats.conflicts = r_stats.conflicts + 32'(i_evt.conflict);
            n_stats.grants    = r_stats.grants    + 32'(i_evt.grant);
            n_stats.reads     = r_stats.reads     + 32'(i_evt.read_grant);
            n_stats.writes    = r_stats.writes    + 32'(i_evt.write_grant);
            n_stats.resolved  = r_stats.resolved  + 32'(i_evt.resolved);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stats <= '0;
        end else begin
            r_stats <= n_stats;
        end
    end

    assign o_stats = r_stats;

endmodule

// ----- hw/rtl/rwlt_checker.sv -----
// ---------------------------------------------------------------------------
// Lock table port checker
// Watches the lock table's ports over time and reports broken behaviour.
// ---------------------------------------------------------------------------
module rwlt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [rwlt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // A result must be held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    // The input side only stalls when a result is waiting on the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("request refused without a stalled result");

    // Only a release can pop a waiter, and a release that pops one reports success.
    a_deq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[rwlt_pkg::OUT_DEQV_BIT] |->
        o_m_tdata[rwlt_pkg::OUT_STATUS_LSB +: 2] == rwlt_pkg::ST_OK)
        else $error("waiter popped by a request that did not succeed");

    // One request adds at most one grant, split into read or write grants.
    a_grant_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready |=> !o_m_tvalid ||
        ((o_m_tdata[rwlt_pkg::OUT_GRANTS_LSB +: 32]
          - $past(o_m_tdata[rwlt_pkg::OUT_GRANTS_LSB +: 32]))
         == (o_m_tdata[rwlt_pkg::OUT_READS_LSB +: 32]
          - $past(o_m_tdata[rwlt_pkg::OUT_READS_LSB +: 32])
          + o_m_tdata[rwlt_pkg::OUT_WRITES_LSB +: 32]
          - $past(o_m_tdata[rwlt_pkg::OUT_WRITES_LSB +: 32]))))
        else $error("grant counters out of step");

    // Reset leaves no result on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind reader_writer_lock_table rwlt_checker u_rwlt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// Readers-writer lock table testbench
// Drives lock and release requests into the table through its stream ports,
// predicts every result from a local copy of the lock state, the wait queues
// and the statistics, and compares each result field by field. The resource
// count is changed between phases, and both stream sides stall at random.
// ---------------------------------------------------------------------------

// Result tdata as a packed struct, first member in the highest bits.
typedef struct packed {
    logic [2:0]                       pad;
    logic [rwlt_pkg::STAT_W-1:0]      resolved;
    logic [rwlt_pkg::STAT_W-1:0]      writes;
    logic [rwlt_pkg::STAT_W-1:0]      reads;
    logic [rwlt_pkg::STAT_W-1:0]      grants;
    logic [rwlt_pkg::STAT_W-1:0]      conflicts;
    logic [rwlt_pkg::PID_W-1:0]       owner_pid;
    logic                             owner_valid;
    logic                             writer_now;
    logic [rwlt_pkg::READERS_W-1:0]   readers_now;
    logic [rwlt_pkg::PID_W-1:0]       deq_pid;
    logic                             deq_valid;
    rwlt_pkg::t_status                status;
} t_lock_result;

class t_lock_scoreboard;
    logic [rwlt_pkg::NFILES_W-1:0]  num_files;
    logic [rwlt_pkg::READERS_W-1:0] readers[rwlt_pkg::MAX_RESOURCES_DEF];
    logic                           writer[rwlt_pkg::MAX_RESOURCES_DEF];
    logic                           active[rwlt_pkg::MAX_RESOURCES_DEF];
    logic [rwlt_pkg::PID_W-1:0]     owner[rwlt_pkg::MAX_RESOURCES_DEF];
    logic [rwlt_pkg::PID_W-1:0]     waiters[rwlt_pkg::MAX_RESOURCES_DEF][$];
    logic [rwlt_pkg::STAT_W-1:0]    conflicts;
    logic [rwlt_pkg::STAT_W-1:0]    grants;
    logic [rwlt_pkg::STAT_W-1:0]    reads;
    logic [rwlt_pkg::STAT_W-1:0]    writes;
    logic [rwlt_pkg::STAT_W-1:0]    resolved;
    t_lock_result                   awaited_results[$];
    int                             errors;

    function new();
        num_files = rwlt_pkg::NUM_FILES_RST;
        for (int i = 0; i < rwlt_pkg::MAX_RESOURCES_DEF; i++) begin
            readers[i] = '0;
            writer[i]  = 1'b0;
            active[i]  = 1'b0;
            owner[i]   = '0;
        end
        conflicts = '0;
        grants    = '0;
        reads     = '0;
        writes    = '0;
        resolved  = '0;
        errors    = 0;
    endfunction

    function int active_count();
        return (num_files > rwlt_pkg::MAX_RESOURCES_DEF) ? rwlt_pkg::MAX_RESOURCES_DEF
                                                         : int'(num_files);
    endfunction

    // Works out the result of one accepted request and updates the lock state.
    function void note_request(logic func, logic [rwlt_pkg::FILE_W-1:0] idx,
                               logic [rwlt_pkg::PID_W-1:0] pid, logic mode);
        t_lock_result res;
        logic         conflict;
        res = '0;
        res.status = rwlt_pkg::ST_OK;
        if (idx >= active_count()) begin
            res.status = rwlt_pkg::ST_NO_RES;
        end else if (func == rwlt_pkg::FUNC_REQUEST) begin
            conflict = (mode == rwlt_pkg::MODE_WRITE) ? (readers[idx] != 0 || writer[idx])
                                                      : writer[idx];
            if (conflict) begin
                if (waiters[idx].size() < rwlt_pkg::WAIT_DEPTH_DEF) begin
                    waiters[idx].push_back(pid);
                    conflicts++;
                    res.status = rwlt_pkg::ST_QUEUED;
                end else begin
                    res.status = rwlt_pkg::ST_FULL;
                end
            end else if (mode == rwlt_pkg::MODE_WRITE) begin
                writer[idx] = 1'b1;
                owner[idx]  = pid;
                active[idx] = 1'b1;
                writes++;
                grants++;
            end else if (readers[idx] == rwlt_pkg::READERS_MAX) begin
                res.status = rwlt_pkg::ST_FULL;
            end else begin
                readers[idx]++;
                if (readers[idx] == 1) begin
                    owner[idx]  = pid;
                    active[idx] = 1'b1;
                end
                reads++;
                grants++;
            end
        end else begin
            // A release that is not by the writing owner counts as a reader release.
            if (writer[idx] && owner[idx] == pid) begin
                writer[idx] = 1'b0;
                active[idx] = 1'b0;
                owner[idx]  = '0;
            end else if (readers[idx] != 0) begin
                readers[idx]--;
                if (readers[idx] == 0) begin
                    active[idx] = 1'b0;
                    owner[idx]  = '0;
                end
            end
            // The head waiter is reported but not granted anything.
            if (waiters[idx].size() != 0) begin
                res.deq_valid = 1'b1;
                res.deq_pid   = waiters[idx].pop_front();
                resolved++;
            end
        end
        if (res.status != rwlt_pkg::ST_NO_RES) begin
            res.readers_now = readers[idx];
            res.writer_now  = writer[idx];
            res.owner_valid = active[idx];
            res.owner_pid   = owner[idx];
        end
        res.conflicts = conflicts;
        res.grants    = grants;
        res.reads     = reads;
        res.writes    = writes;
        res.resolved  = resolved;
        awaited_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            errors++;
        end
    endfunction

    function void check_result(t_lock_result got);
        t_lock_result exp;
        if (awaited_results.size() == 0) begin
            $error("result: expected none, got %0h", got);
            errors++;
            return;
        end
        exp = awaited_results.pop_front();
        compare_field("status", 32'(exp.status), 32'(got.status));
        compare_field("dequeued_valid", 32'(exp.deq_valid), 32'(got.deq_valid));
        compare_field("dequeued_pid", 32'(exp.deq_pid), 32'(got.deq_pid));
        compare_field("readers_now", 32'(exp.readers_now), 32'(got.readers_now));
        compare_field("writer_now", 32'(exp.writer_now), 32'(got.writer_now));
        compare_field("owner_valid", 32'(exp.owner_valid), 32'(got.owner_valid));
        compare_field("owner_pid", 32'(exp.owner_pid), 32'(got.owner_pid));
        compare_field("conflicts_total", exp.conflicts, got.conflicts);
        compare_field("grants_total", exp.grants, got.grants);
        compare_field("read_grants_total", exp.reads, got.reads);
        compare_field("write_grants_total", exp.writes, got.writes);
        compare_field("resolved_total", exp.resolved, got.resolved);
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [rwlt_pkg::NFILES_W-1:0]        i_cfg_wdata = '0;
    logic                                 i_s_tvalid = 1'b0;
    logic                                 o_s_tready;
    logic [rwlt_pkg::IN_TDATA_W-1:0]      i_s_tdata = '0;
    logic [0:0]                           i_s_tuser = '0;
    logic                                 o_m_tvalid;
    logic                                 i_m_tready = 1'b0;
    logic [rwlt_pkg::OUT_TDATA_W-1:0]     o_m_tdata;

    t_lock_scoreboard           predictor = new();
    int                         cycle_count = 0;
    int                         requests_sent = 0;
    int                         settings_used = 0;
    bit                         quiet = 1'b0;
    bit                         hold_request = 1'b0;
    bit                         hold_taken = 1'b0;

    reader_writer_lock_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Offers one request, waits for it to be taken, then perhaps idles.
    // Inputs are stable at the falling edge, so the handshake is judged there.
    task automatic offer_request(input logic func, input logic [rwlt_pkg::FILE_W-1:0] idx,
                                 input logic [rwlt_pkg::PID_W-1:0] pid, input logic mode);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, mode, pid, idx};
        i_s_tuser  <= func;
        do @(negedge i_clk); while (o_s_tready !== 1'b1);
        predictor.note_request(func, idx, pid, mode);
        requests_sent++;
        @(posedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (predictor.awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_file_count(input logic [rwlt_pkg::NFILES_W-1:0] count);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        predictor.num_files = count;
        settings_used++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random traffic over a few resources so that conflicts and queues build up.
    // Releases of a write-held resource mostly come from its owner, so that write locks do clear.
    task automatic random_phase(input logic [rwlt_pkg::NFILES_W-1:0] count, input int span,
                                input int items);
        logic                         func;
        logic [rwlt_pkg::FILE_W-1:0]  idx;
        logic [rwlt_pkg::PID_W-1:0]   pid;
        logic                         mode;
        int                           lim;
        set_file_count(count);
        repeat (items) begin
            lim = (span < predictor.active_count()) ? span : predictor.active_count();
            if (lim == 0 || $urandom_range(0, 15) == 0)
                idx = 4'($urandom);
            else
                idx = 4'($urandom_range(0, lim - 1));
            func = ($urandom_range(0, 9) < 6) ? rwlt_pkg::FUNC_REQUEST : rwlt_pkg::FUNC_RELEASE;
            mode = 1'($urandom_range(0, 1));
            pid  = 16'($urandom);
            if (func == rwlt_pkg::FUNC_RELEASE && predictor.writer[idx]
                && $urandom_range(0, 3) != 0)
                pid = predictor.owner[idx];
            offer_request(func, idx, pid, mode);
        end
    endtask

    // Result side: random stalls, and one long hold-off when asked for.
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_request && !hold_taken) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_taken = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (o_m_tvalid === 1'b1 && i_m_tready === 1'b1)
                predictor.check_result(o_m_tdata);
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first with the reset resource count, then with zero and one resources.
        offer_request(rwlt_pkg::FUNC_REQUEST, 4'd0, 16'h0000, rwlt_pkg::MODE_READ);
        offer_request(rwlt_pkg::FUNC_REQUEST, 4'd0, 16'hFFFF, rwlt_pkg::MODE_WRITE);
        offer_request(rwlt_pkg::FUNC_RELEASE, 4'd0, 16'h1234, rwlt_pkg::MODE_READ);
        offer_request(rwlt_pkg::FUNC_REQUEST, 4'd15, 16'hFFFF, rwlt_pkg::MODE_WRITE);
        offer_request(rwlt_pkg::FUNC_REQUEST, 4'd15, 16'hAAAA, rwlt_pkg::MODE_READ);
        // A stranger releasing a write-held resource releases nothing.
        offer_request(rwlt_pkg::FUNC_RELEASE, 4'd15, 16'h5555, rwlt_pkg::MODE_WRITE);
        offer_request(rwlt_pkg::FUNC_RELEASE, 4'd15, 16'hFFFF, rwlt_pkg::MODE_WRITE);
        // Release with nothing held and nobody waiting.
        offer_request(rwlt_pkg::FUNC_RELEASE, 4'd3, 16'h0000, rwlt_pkg::MODE_READ);
        // Fill one wait queue and go one past it.
        offer_request(rwlt_pkg::FUNC_REQUEST, 4'd7, 16'h0001, rwlt_pkg::MODE_WRITE);
        for (int i = 0; i <= rwlt_pkg::WAIT_DEPTH_DEF; i++)
            offer_request(rwlt_pkg::FUNC_REQUEST, 4'd7, 16'(16'h0100 + i),
                          rwlt_pkg::MODE_READ);
        offer_request(rwlt_pkg::FUNC_RELEASE, 4'd7, 16'h0001, rwlt_pkg::MODE_READ);
        set_file_count(5'd0);
        offer_request(rwlt_pkg::FUNC_REQUEST, 4'd0, 16'h0042, rwlt_pkg::MODE_READ);
        set_file_count(5'd1);
        offer_request(rwlt_pkg::FUNC_REQUEST, 4'd1, 16'h0043, rwlt_pkg::MODE_WRITE);
        offer_request(rwlt_pkg::FUNC_RELEASE, 4'd0, 16'h0044, rwlt_pkg::MODE_WRITE);

        // Reader flood up to and past the reader limit, while the result side holds off.
        set_file_count(5'd16);
        hold_request = 1'b1;
        repeat (rwlt_pkg::READERS_MAX + 5)
            offer_request(rwlt_pkg::FUNC_REQUEST, 4'd9, 16'($urandom), rwlt_pkg::MODE_READ);
        offer_request(rwlt_pkg::FUNC_REQUEST, 4'd9, 16'($urandom), rwlt_pkg::MODE_WRITE);
        repeat (4)
            offer_request(rwlt_pkg::FUNC_RELEASE, 4'd9, 16'($urandom),
                          1'($urandom_range(0, 1)));

        random_phase(5'd31, 4, 170);
        random_phase(5'd5, 3, 170);
        random_phase(5'($urandom_range(2, 16)), 4, 170);
        wait_for_results();
        quiet = 1'b1;
        random_phase(5'd16, 4, 170);

        wait_for_results();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d requests under %0d resource-count settings, including the reader limit",
                 requests_sent, settings_used);
        $display("and full wait queues: %0d grants, %0d queued, %0d waiters popped.",
                 predictor.grants, predictor.conflicts, predictor.resolved);
        if (predictor.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
